// ===== rtl/core/ipv4_dotted_quad_parser_unit_assert.svh =====
// Assertion macros shared by the dotted-quad parser RTL.
`ifndef IPV4_DOTTED_QUAD_PARSER_UNIT_ASSERT_SVH
`define IPV4_DOTTED_QUAD_PARSER_UNIT_ASSERT_SVH

// Check that a condition holds in every cycle outside reset.
`define IPV4DQP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check that a trigger is followed, in the next cycle, by a condition.
`define IPV4DQP_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/core/ipv4dqp_pkg.sv =====
// Types and constants for the IPv4 dotted-quad parser.
package ipv4dqp_pkg;

  // ASCII codes and limits used by the octet parser
  localparam logic [7:0] DotChar   = 8'h2E;
  localparam logic [7:0] ZeroChar  = 8'h30;
  localparam logic [7:0] NineChar  = 8'h39;
  localparam logic [11:0] OctetMax = 12'd255;
  localparam logic [1:0] LastOctet = 2'd3;

  // One byte of the address string
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } in_item_t;

  // Parse result, given on the last byte of a string
  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
  } out_item_t;

endpackage

// ===== rtl/core/ipv4dqp_in_reg.sv =====
// Input register stage of the dotted-quad parser.
module ipv4dqp_in_reg
  import ipv4dqp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     item_valid_o,
  output in_item_t item_o,
  input  logic     item_take_i
);

  logic     valid_q, valid_d;
  in_item_t item_q, item_d;
  logic     load;

  // Refill whenever the held item is empty or leaves this cycle
  assign in_stall_o = valid_q && !item_take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = 1'b1;
      item_d  = in_data_i;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/core/ipv4dqp_core.sv =====
// Per-byte parse state and result logic of the dotted-quad parser.
`include "ipv4_dotted_quad_parser_unit_assert.svh"

module ipv4dqp_core
  import ipv4dqp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  input  in_item_t  item_i,
  output logic      item_take_o,
  input  logic      res_ready_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  logic [1:0]  idx_q, idx_d;
  logic [7:0]  val_q, val_d;
  logic        seen_q, seen_d;
  logic        failed_q, failed_d;
  logic        tail_q, tail_d;
  logic [23:0] upper_q, upper_d;

  logic        is_dot;
  logic        is_digit;
  logic [7:0]  digit;
  logic [11:0] acc;
  logic        ok;

  // Classify the byte; value * 10 + digit as two shifted adds
  assign is_dot   = item_i.ch == DotChar;
  assign is_digit = (item_i.ch >= ZeroChar) && (item_i.ch <= NineChar);
  assign digit    = item_i.ch - ZeroChar;
  assign acc      = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0} + {8'h00, digit[3:0]};

  // Advance the parse state by one byte
  always_comb begin
    idx_d    = idx_q;
    val_d    = val_q;
    seen_d   = seen_q;
    failed_d = failed_q;
    tail_d   = tail_q;
    upper_d  = upper_q;
    if (item_i.has_char && !failed_q && !tail_q) begin
      priority if (is_dot) begin
        priority if (!seen_q) begin
          failed_d = 1'b1;
        end else if (idx_q != LastOctet) begin
          upper_d = {upper_q[15:0], val_q};
          idx_d   = idx_q + 2'd1;
          val_d   = 8'h00;
          seen_d  = 1'b0;
        end else begin
          tail_d = 1'b1;
        end
      end else if (is_digit) begin
        if (acc > OctetMax) begin
          failed_d = 1'b1;
        end else begin
          val_d  = acc[7:0];
          seen_d = 1'b1;
        end
      end else begin
        failed_d = 1'b1;
      end
    end
  end

  // Final verdict on the updated state
  assign ok = !failed_d && (tail_d || ((idx_d == LastOctet) && seen_d));

  assign res_o.ok   = ok;
  assign res_o.addr = ok ? {upper_d, val_d} : 32'h0000_0000;

  // A last byte needs room for its result; other bytes always pass
  assign item_take_o = item_valid_i && (!item_i.last || res_ready_i);
  assign res_valid_o = item_take_o && item_i.last;

  // Commit the new state; drop it back to reset after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 2'd0;
      val_q    <= 8'h00;
      seen_q   <= 1'b0;
      failed_q <= 1'b0;
      tail_q   <= 1'b0;
      upper_q  <= 24'h00_0000;
    end else if (item_take_o) begin
      if (item_i.last) begin
        idx_q    <= 2'd0;
        val_q    <= 8'h00;
        seen_q   <= 1'b0;
        failed_q <= 1'b0;
        tail_q   <= 1'b0;
        upper_q  <= 24'h00_0000;
      end else begin
        idx_q    <= idx_d;
        val_q    <= val_d;
        seen_q   <= seen_d;
        failed_q <= failed_d;
        tail_q   <= tail_d;
        upper_q  <= upper_d;
      end
    end
  end

  `IPV4DQP_ASSERT_ALWAYS(a_fail_tail_excl, !(failed_q && tail_q), "failed and tail both set")
  `IPV4DQP_ASSERT_ALWAYS(a_tail_in_fourth, !tail_q || (idx_q == LastOctet), "tail before fourth octet")
  `IPV4DQP_ASSERT_NEXT(a_clear_after_last, res_valid_o, (idx_q == 2'd0) && !seen_q && !failed_q && !tail_q, "state not cleared after last byte")

endmodule

// ===== rtl/core/ipv4dqp_out_buf.sv =====
// Output register with one skid entry for the dotted-quad parser.
`include "ipv4_dotted_quad_parser_unit_assert.svh"

module ipv4dqp_out_buf
  import ipv4dqp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_valid_i,
  input  out_item_t res_i,
  output logic      res_ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      skid_full_q, skid_full_d;
  out_item_t skid_q, skid_d;
  logic      xfer;

  assign res_ready_o = !skid_full_q;
  assign xfer        = out_valid_q && !out_stall_i;

  // Fill the output register first, park in the skid entry when it is held
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    skid_full_d = skid_full_q;
    skid_d      = skid_q;
    if (res_valid_i) begin
      if (!out_valid_q || xfer) begin
        out_valid_d = 1'b1;
        out_d       = res_i;
      end else begin
        skid_full_d = 1'b1;
        skid_d      = res_i;
      end
    end else if (xfer) begin
      if (skid_full_q) begin
        out_d       = skid_q;
        skid_full_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `IPV4DQP_ASSERT_ALWAYS(a_skid_behind_out, !skid_full_q || out_valid_q, "skid entry without output")

endmodule

// ===== rtl/core/ipv4_dotted_quad_parser_unit.sv =====
// Top level of the IPv4 dotted-quad parser.
//
// Parses an IPv4 dotted-decimal string fed one byte per transfer and, on the
// transfer marked last, gives one result: ok and the 32-bit address (first
// octet in the top byte, zero when the parse fails). A byte may be taken in
// every cycle; a byte goes from the input register through the parse logic
// into the output register, from which its result is offered. The output
// register has one skid entry behind it, so input keeps flowing while a
// result waits; the input stalls only when both are full and a last byte
// is waiting.
module ipv4_dotted_quad_parser_unit
  import ipv4dqp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      item_valid;
  in_item_t  item;
  logic      item_take;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  ipv4dqp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  ipv4dqp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ipv4dqp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/ipv4_dotted_quad_parser_unit_checker.sv =====
// Checker for the dotted-quad parser: predicts each parse result and compares it.
`timescale 1ns / 1ps

module ipv4_dotted_quad_parser_unit_checker
  import ipv4dqp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        mismatch_count_o,
  output int        outstanding_o
);

  // Predicted parser state
  logic [1:0]  octets_closed;
  logic [7:0]  octet_acc;
  logic        digit_in_octet;
  logic        parse_failed;
  logic        tail_skipped;
  logic [23:0] closed_octets;

  // Parse results still owed by the block, oldest first
  out_item_t   parsed_q[$];
  int          mismatches;

  task automatic clear_parse();
    octets_closed  = '0;
    octet_acc      = '0;
    digit_in_octet = 1'b0;
    parse_failed   = 1'b0;
    tail_skipped   = 1'b0;
    closed_octets  = '0;
  endtask

  // Advance the predicted state by one byte of the string
  task automatic absorb_byte(input logic [7:0] c);
    logic [11:0] next_val;
    if (parse_failed || tail_skipped) return;
    if (c == DotChar) begin
      if (!digit_in_octet) begin
        parse_failed = 1'b1;
      end else if (octets_closed != LastOctet) begin
        closed_octets  = {closed_octets[15:0], octet_acc};
        octets_closed  = octets_closed + 2'd1;
        octet_acc      = '0;
        digit_in_octet = 1'b0;
      end else begin
        // fourth octet closed: drop the rest of the string
        tail_skipped = 1'b1;
      end
    end else if (c >= ZeroChar && c <= NineChar) begin
      next_val = 12'(octet_acc) * 12'd10 + 12'(c - ZeroChar);
      if (next_val > OctetMax) begin
        parse_failed = 1'b1;
      end else begin
        octet_acc      = next_val[7:0];
        digit_in_octet = 1'b1;
      end
    end else begin
      parse_failed = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t verdict;
    out_item_t want;
    if (!rst_ni) begin
      clear_parse();
      parsed_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      // Predict on every input transfer; a last byte closes the string
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.has_char) absorb_byte(in_data_i.ch);
        if (in_data_i.last) begin
          verdict.ok = !parse_failed &&
                       (tail_skipped || (octets_closed == LastOctet && digit_in_octet));
          verdict.addr = verdict.ok ? {closed_octets, octet_acc} : '0;
          parsed_q.push_back(verdict);
          clear_parse();
        end
      end
      // Compare each output transfer with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (parsed_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: ok=%0b addr=%08h", out_data_i.ok, out_data_i.addr);
          mismatches++;
        end else begin
          want = parsed_q.pop_front();
          if (out_data_i.ok !== want.ok || out_data_i.addr !== want.addr) begin
            if (mismatches < 10)
              $display("parse mismatch: expected ok=%0b addr=%08h, got ok=%0b addr=%08h",
                       want.ok, want.addr, out_data_i.ok, out_data_i.addr);
            mismatches++;
          end
        end
      end
      mismatch_count_o <= mismatches;
      outstanding_o <= parsed_q.size();
    end
  end

endmodule

// ===== test/ipv4_dotted_quad_parser_unit_test.sv =====
// Testbench top for the dotted-quad parser: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module ipv4_dotted_quad_parser_unit_test;
  import ipv4dqp_pkg::*;

  localparam int RandomItems = 2000;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 5000;
  localparam int DrainCycles = 8;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  logic      calm;
  logic      hold_req;
  int        sent_items = 0;
  int        idle_cycles = 0;
  int        mismatch_count;
  int        outstanding;
  logic [7:0] text_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ipv4_dotted_quad_parser_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  ipv4_dotted_quad_parser_unit_checker u_parse_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  // Offer one item, idling at random first, and hold it until the transfer
  task automatic send_item(input in_item_t item);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  // Send the bytes in text_q as one string, with occasional byteless items
  task automatic send_text(input bit blank_end);
    in_item_t item;
    foreach (text_q[i]) begin
      if ($urandom_range(99) < 4) begin
        item.ch       = 8'($urandom);
        item.has_char = 1'b0;
        item.last     = 1'b0;
        send_item(item);
      end
      item.ch       = text_q[i];
      item.has_char = 1'b1;
      item.last     = !blank_end && (i == text_q.size() - 1);
      send_item(item);
    end
    if (blank_end || text_q.size() == 0) begin
      item.ch       = 8'($urandom);
      item.has_char = 1'b0;
      item.last     = 1'b1;
      send_item(item);
    end
  endtask

  task automatic load_text(input string s);
    text_q.delete();
    for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
  endtask

  task automatic push_number(input int unsigned value, input int unsigned zeros);
    string digits;
    digits = $sformatf("%0d", value);
    repeat (zeros) text_q.push_back(ZeroChar);
    for (int k = 0; k < digits.len(); k++) text_q.push_back(digits[k]);
  endtask

  // Receiver: random stalls, a calm stretch, and one long hold-off
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end
      out_stall <= !calm && ($urandom_range(99) < 26);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int          kind;
    int          octets;
    int          bad_pos;
    int          start_count;
    int unsigned v;
    logic [7:0]  c;
    bit          blank_end;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    calm     <= 1'b0;
    hold_req <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings: extremes, empty, tail after fourth dot, each failure kind
    load_text("255.255.255.255");
    send_text(1'b0);
    text_q.delete();
    send_text(1'b0);
    load_text("0.0.0.0.");
    text_q.push_back(8'hFF);
    send_text(1'b1);
    load_text("256");
    send_text(1'b0);
    load_text(".");
    send_text(1'b0);
    text_q = {8'h80};
    send_text(1'b0);
    load_text("9x9");
    send_text(1'b0);
    load_text("1.2");
    send_text(1'b0);

    // Random strings: mostly well formed, the rest broken or noise
    start_count = sent_items;
    while (sent_items - start_count < RandomItems) begin
      calm <= (sent_items - start_count >= 700) && (sent_items - start_count < 1000);
      if (sent_items - start_count >= 1300) hold_req <= 1'b1;
      text_q.delete();
      blank_end = ($urandom_range(9) == 0);
      kind      = $urandom_range(99);
      octets    = (kind >= 88 && kind < 94) ? $urandom_range(1, 3) : 4;
      bad_pos   = $urandom_range(0, octets - 1);
      if (kind >= 97) begin
        repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom));
      end else if (kind < 94) begin
        for (int o = 0; o < octets; o++) begin
          if (o > 0) text_q.push_back(DotChar);
          // leave this octet empty
          if (kind >= 70 && kind < 78 && o == bad_pos) continue;
          if (kind >= 60 && kind < 70 && o == bad_pos) v = $urandom_range(256, 99999);
          else if ($urandom_range(3) == 0) v = $urandom_range(1) ? 255 : 0;
          else v = $urandom_range(255);
          push_number(v, ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
          // stray non-digit byte, high bytes included
          if (kind >= 78 && kind < 88 && o == bad_pos) begin
            do c = 8'($urandom);
            while (c == DotChar || (c >= ZeroChar && c <= NineChar));
            text_q.push_back(c);
          end
        end
        if (kind < 60 && $urandom_range(4) == 0) begin
          text_q.push_back(DotChar);
          repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom));
        end
      end
      send_text(blank_end);
    end

    // Drain: wait for every predicted result, then for the pipeline
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
